### rtl/core/pmd_pkg.sv
// Shared types and constants for the PID motor drive block.
// Used by every module under rtl/core; depends on nothing.
package pmd_pkg;

	localparam int ACC_WIDTH_DEF = 48;

	// Configuration register file
	localparam int CFG_IDX_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN     = 4'd0,
		REG_INTEG_GAIN    = 4'd1,
		REG_DERIV_GAIN    = 4'd2,
		REG_SAMPLE_PERIOD = 4'd3,
		REG_NEAR_BAND     = 4'd4,
		REG_NEAR_LIMIT    = 4'd5,
		REG_DEAD_ERROR    = 4'd6,
		REG_DEAD_OUTPUT   = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] prop_gain;
		logic signed [31:0] integ_gain;
		logic signed [31:0] deriv_gain;
		logic [9:0]         sample_period;
		logic [15:0]        near_band;
		logic [7:0]         near_limit;
		logic [15:0]        dead_error;
		logic [7:0]         dead_output;
	} cfg_t;

	localparam logic signed [31:0] PROP_GAIN_RST     = 32'sd83886080;
	localparam logic signed [31:0] INTEG_GAIN_RST    = 32'sd1678;
	localparam logic signed [31:0] DERIV_GAIN_RST    = 32'sd167772;
	localparam logic [9:0]         SAMPLE_PERIOD_RST = 10'd20;
	localparam logic [15:0]        NEAR_BAND_RST     = 16'd100;
	localparam logic [7:0]         NEAR_LIMIT_RST    = 8'd100;
	localparam logic [15:0]        DEAD_ERROR_RST    = 16'd3;
	localparam logic [7:0]         DEAD_OUTPUT_RST   = 8'd50;

	// Chunked gain multiply: 16-bit operand chunks
	localparam int NC_E = 3;  // error, 33 bits signed
	localparam int NC_D = 4;  // derivative, 50 bits signed

	// Derivative divider: 50-bit dividend, two quotient bits per cycle
	localparam int DIV_W     = 50;
	localparam int DIV_STEPS = DIV_W / 2;

	// Q40 sum, integer part saturates at 2^20, drive clamps at 255
	localparam int FRAC_BITS = 40;
	localparam int SAT_LIM   = 1 << 20;
	localparam int DRIVE_MAX = 255;

	typedef enum logic [1:0] {
		TERM_P = 2'b00,
		TERM_I = 2'b01,
		TERM_D = 2'b10
	} term_t;

	// Controller to datapath
	typedef struct packed {
		logic       load_err;
		logic       prep;
		logic       integ;
		logic       mul_go;
		term_t      term;
		logic [1:0] chunk;
		logic       top;
		logic       trunc;
		logic       out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
		logic out_free;
	} status_t;

endpackage

### rtl/core/pid_motor_drive_with_deadband_top.sv
// Top level of the PID motor drive block with error deadband and near-target limit.
// Depends on pmd_pkg, pmd_cfg, pmd_ctrl and pmd_dp.

// Each transfer on the input channel carries a target and a measured encoder count and
// produces exactly one signed drive value (-255..255) on the output channel. The block
// forms the 33-bit error, adds error times sample_period into a saturating ACC_WIDTH-bit
// integral, divides the change in error by the period (signed Q16, truncated toward
// zero), and sums Kp*e + Ki*I + Kd*d exactly in a Q40 accumulator. The sum is truncated
// toward zero and saturated at +-2^20, then clamped to +-near_limit when |e| < near_band,
// zeroed when |e| < dead_error and |drive| < dead_output, and finally clamped to +-255.
// Timing: an item occupies the block from its input transfer until its result is
// loaded into the output register, a load that waits while the previous result is
// still held and the output is stalled. How long an item takes is set by the
// derivative divider, which retires two quotient bits per cycle over a 50-bit
// dividend; the proportional and integral products run on the shared 32x17
// multiplier in 16-bit chunks while the divider works, and the derivative
// product, accumulate, truncate and limit steps follow it. A finished result waits in
// the output register, so a new item is taken while the result is still held. Sample
// periods of zero act as one. Configuration writes are taken in any cycle (cfg_ready is
// always high) but must only be issued while no item is in flight; indexes beyond the
// eight registers are dropped. Reset clears the integral and the stored last error and
// restores the default gains and limits; no clearing pass is needed.
module pid_motor_drive_with_deadband_top #(
	parameter int ACC_WIDTH = pmd_pkg::ACC_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [31:0]             target_count,
	input  logic signed [31:0]             measured_count,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [8:0]              drive,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	pmd_pkg::cfg_t    cfg;
	pmd_pkg::cmd_t    cmd;
	pmd_pkg::status_t status;

	// Register file: gains, period and limits
	pmd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Sequencer: accept, prepare, multiply passes, truncate, hand off
	pmd_ctrl #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic, divider, state and output register
	pmd_dp #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg            (cfg),
		.target_count   (target_count),
		.measured_count (measured_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.drive          (drive)
	);

endmodule

### rtl/core/pmd_cfg.sv
// Configuration register file of the PID motor drive block.
// Depends on pmd_pkg for register indexes, reset values and cfg_t.
module pmd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	output pmd_pkg::cfg_t                  cfg
);

	pmd_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= pmd_pkg::PROP_GAIN_RST;
			cfg_q.integ_gain    <= pmd_pkg::INTEG_GAIN_RST;
			cfg_q.deriv_gain    <= pmd_pkg::DERIV_GAIN_RST;
			cfg_q.sample_period <= pmd_pkg::SAMPLE_PERIOD_RST;
			cfg_q.near_band     <= pmd_pkg::NEAR_BAND_RST;
			cfg_q.near_limit    <= pmd_pkg::NEAR_LIMIT_RST;
			cfg_q.dead_error    <= pmd_pkg::DEAD_ERROR_RST;
			cfg_q.dead_output   <= pmd_pkg::DEAD_OUTPUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pmd_pkg::reg_idx_t'(cfg_index))
				pmd_pkg::REG_PROP_GAIN:     cfg_q.prop_gain     <= cfg_data;
				pmd_pkg::REG_INTEG_GAIN:    cfg_q.integ_gain    <= cfg_data;
				pmd_pkg::REG_DERIV_GAIN:    cfg_q.deriv_gain    <= cfg_data;
				pmd_pkg::REG_SAMPLE_PERIOD: cfg_q.sample_period <= cfg_data[9:0];
				pmd_pkg::REG_NEAR_BAND:     cfg_q.near_band     <= cfg_data[15:0];
				pmd_pkg::REG_NEAR_LIMIT:    cfg_q.near_limit    <= cfg_data[7:0];
				pmd_pkg::REG_DEAD_ERROR:    cfg_q.dead_error    <= cfg_data[15:0];
				pmd_pkg::REG_DEAD_OUTPUT:   cfg_q.dead_output   <= cfg_data[7:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

endmodule

### rtl/core/pmd_div.sv
// Iterative unsigned divider, two quotient bits per cycle, for the derivative term.
// Depends on pmd_pkg for the dividend width and step count.
module pmd_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pmd_pkg::DIV_W-1:0] dividend,
	input  logic [9:0]                 divisor,
	output logic [pmd_pkg::DIV_W-1:0] quotient,
	output logic                       done
);

	localparam int CNT_W = $clog2(pmd_pkg::DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(pmd_pkg::DIV_STEPS - 1);

	logic [pmd_pkg::DIV_W-1:0] quo_q;
	logic [9:0]                rem_q;
	logic [9:0]                dsr_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic [pmd_pkg::DIV_W-1:0] quo_d;
	logic [9:0]                rem_d;

	// Two restoring steps; remainder always stays below the divisor
	always_comb begin
		logic [10:0] t;
		t     = '0;
		quo_d = quo_q;
		rem_d = rem_q;
		for (int i = 0; i < 2; i++) begin
			t     = {rem_d, quo_d[pmd_pkg::DIV_W-1]};
			quo_d = {quo_d[pmd_pkg::DIV_W-2:0], 1'b0};
			if (t >= {1'b0, dsr_q}) begin
				t        = t - {1'b0, dsr_q};
				quo_d[0] = 1'b1;
			end
			rem_d = t[9:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

### rtl/core/pmd_dp.sv
// Datapath of the PID motor drive block: error, integral, derivative divider,
// shared chunked gain multiplier, Q40 accumulator, limiting and output register.
// Depends on pmd_pkg and pmd_div.
module pmd_dp #(
	parameter int ACC_WIDTH = pmd_pkg::ACC_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pmd_pkg::cmd_t      cmd,
	output pmd_pkg::status_t   status,
	input  pmd_pkg::cfg_t      cfg,
	input  logic signed [31:0] target_count,
	input  logic signed [31:0] measured_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [8:0]  drive
);

	localparam int XW  = 44;  // error times period
	localparam int SW  = ((ACC_WIDTH > XW) ? ACC_WIDTH : XW) + 1;
	localparam int TW  = ACC_WIDTH + 50;
	localparam int IPW = TW - pmd_pkg::FRAC_BITS;
	localparam int DW  = pmd_pkg::DIV_W;

	logic signed [32:0]          err_q;
	logic signed [32:0]          last_err_q;
	logic signed [ACC_WIDTH-1:0] integ_q;
	logic signed [XW-1:0]        x_q;
	logic                        dneg_q;
	logic                        near_q;
	logic                        dead_q;
	logic signed [TW-1:0]        total_q;
	logic signed [48:0]          prod_s1;
	logic [2:0]                  shift_s1;
	logic                        mv_s1;
	logic [20:0]                 mag_q;
	logic                        neg_q;
	logic                        out_valid_q;
	logic signed [8:0]           drive_q;

	// Error stage
	logic [9:0]          period;
	logic signed [33:0]  diff;
	logic [33:0]         diff_mag;
	logic [32:0]         err_mag;
	logic [DW-1:0]       dividend;
	logic [DW-1:0]       quo;
	logic                div_done;
	logic signed [XW-1:0] x;

	assign period   = (cfg.sample_period == '0) ? 10'd1 : cfg.sample_period;
	assign diff     = 34'(err_q) - 34'(last_err_q);
	assign diff_mag = diff[33] ? -diff : diff;
	assign err_mag  = err_q[32] ? -err_q : err_q;
	assign dividend = {1'b0, diff_mag[32:0], 16'b0};
	assign x        = XW'(err_q) * XW'($signed({1'b0, period}));

	pmd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.prep),
		.dividend (dividend),
		.divisor  (period),
		.quotient (quo),
		.done     (div_done)
	);

	// Saturating integral update
	logic signed [SW-1:0]        isum;
	logic                        hi_ovf;
	logic                        lo_ovf;
	logic signed [ACC_WIDTH-1:0] integ_next;

	assign isum   = SW'(integ_q) + SW'(x_q);
	assign hi_ovf = !isum[SW-1] && (isum[SW-2:ACC_WIDTH-1] != '0);
	assign lo_ovf = isum[SW-1] && !(&isum[SW-2:ACC_WIDTH-1]);

	always_comb begin
		if (hi_ovf)
			integ_next = {1'b0, {(ACC_WIDTH-1){1'b1}}};
		else if (lo_ovf)
			integ_next = {1'b1, {(ACC_WIDTH-1){1'b0}}};
		else
			integ_next = isum[ACC_WIDTH-1:0];
	end

	// Chunked gain multiply and accumulate
	logic [DW-1:0]       dq_bits;
	logic [63:0]         opnd;
	logic signed [31:0]  gain;
	logic [15:0]         chunk;
	logic signed [16:0]  chunk17;
	logic [2:0]          shift_base;
	logic signed [TW-1:0] addend;

	assign dq_bits = dneg_q ? (~quo + 1'b1) : quo;

	always_comb begin
		case (cmd.term)
			pmd_pkg::TERM_P: begin
				opnd       = 64'(err_q);
				gain       = cfg.prop_gain;
				shift_base = 3'd1;
			end
			pmd_pkg::TERM_I: begin
				opnd       = 64'(integ_q);
				gain       = cfg.integ_gain;
				shift_base = 3'd1;
			end
			pmd_pkg::TERM_D: begin
				opnd       = {{(64-DW){dq_bits[DW-1]}}, dq_bits};
				gain       = cfg.deriv_gain;
				shift_base = 3'd0;
			end
			default: begin
				opnd       = '0;
				gain       = '0;
				shift_base = 3'd0;
			end
		endcase
	end

	assign chunk   = opnd[{cmd.chunk, 4'b0} +: 16];
	assign chunk17 = cmd.top ? {chunk[15], chunk} : {1'b0, chunk};
	assign addend  = TW'(prod_s1) << {shift_s1, 4'b0};

	// Q40 to integer, truncated toward zero, saturated
	logic [TW-1:0]  tmag;
	logic [IPW-1:0] ip;
	logic           sat;

	assign tmag = total_q[TW-1] ? -total_q : total_q;
	assign ip   = tmag[TW-1:pmd_pkg::FRAC_BITS];
	assign sat  = ip > IPW'(pmd_pkg::SAT_LIM);

	// Near-band clamp, deadband, final clamp
	logic [20:0] m_near;
	logic [20:0] m_dead;
	logic [7:0]  m_fin;
	logic [8:0]  drive_next;

	always_comb begin
		m_near = (near_q && mag_q > 21'(cfg.near_limit)) ? 21'(cfg.near_limit) : mag_q;
		m_dead = (dead_q && m_near < 21'(cfg.dead_output)) ? '0 : m_near;
		m_fin  = (m_dead > 21'(pmd_pkg::DRIVE_MAX)) ? 8'(pmd_pkg::DRIVE_MAX) : m_dead[7:0];
		drive_next = neg_q ? (9'd0 - {1'b0, m_fin}) : {1'b0, m_fin};
	end

	// Controller state: integral and last error, plus the product valid and output valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			last_err_q  <= '0;
			mv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.prep)
				last_err_q <= err_q;
			if (cmd.integ)
				integ_q <= integ_next;
			mv_s1 <= cmd.mul_go;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_err)
			err_q <= 33'(target_count) - 33'(measured_count);
		if (cmd.prep) begin
			x_q     <= x;
			dneg_q  <= diff[33];
			near_q  <= err_mag < 33'(cfg.near_band);
			dead_q  <= err_mag < 33'(cfg.dead_error);
			total_q <= '0;
		end else if (mv_s1) begin
			total_q <= total_q + addend;
		end
		if (cmd.mul_go) begin
			prod_s1  <= gain * chunk17;
			shift_s1 <= {1'b0, cmd.chunk} + shift_base;
		end
		if (cmd.trunc) begin
			neg_q <= total_q[TW-1];
			mag_q <= sat ? 21'(pmd_pkg::SAT_LIM) : ip[20:0];
		end
		if (cmd.out_load)
			drive_q <= drive_next;
	end

	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign drive           = drive_q;

endmodule

### rtl/core/pmd_ctrl.sv
// Sequencing state machine of the PID motor drive block.
// Depends on pmd_pkg for the command and status structs.
module pmd_ctrl #(
	parameter int ACC_WIDTH = pmd_pkg::ACC_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  pmd_pkg::status_t status,
	output pmd_pkg::cmd_t    cmd
);

	localparam int NC_I = (ACC_WIDTH + 15) / 16;
	localparam logic [1:0] LAST_P = 2'(pmd_pkg::NC_E - 1);
	localparam logic [1:0] LAST_I = 2'(NC_I - 1);
	localparam logic [1:0] LAST_D = 2'(pmd_pkg::NC_D - 1);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_PREP   = 10'b00_0000_0010,
		S_INTEG  = 10'b00_0000_0100,
		S_MUL_P  = 10'b00_0000_1000,
		S_MUL_I  = 10'b00_0001_0000,
		S_WAIT_D = 10'b00_0010_0000,
		S_MUL_D  = 10'b00_0100_0000,
		S_DRAIN  = 10'b00_1000_0000,
		S_TRUNC  = 10'b01_0000_0000,
		S_OUT    = 10'b10_0000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_err = 1'b1;
					state_d      = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_INTEG;
			end
			S_INTEG: begin
				cmd.integ = 1'b1;
				cnt_d     = '0;
				state_d   = S_MUL_P;
			end
			S_MUL_P: begin
				cmd.mul_go = 1'b1;
				cmd.term   = pmd_pkg::TERM_P;
				cmd.chunk  = cnt_q;
				cmd.top    = (cnt_q == LAST_P);
				if (cnt_q == LAST_P) begin
					cnt_d   = '0;
					state_d = S_MUL_I;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_MUL_I: begin
				cmd.mul_go = 1'b1;
				cmd.term   = pmd_pkg::TERM_I;
				cmd.chunk  = cnt_q;
				cmd.top    = (cnt_q == LAST_I);
				if (cnt_q == LAST_I) begin
					cnt_d   = '0;
					state_d = S_WAIT_D;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_WAIT_D: begin
				if (status.div_done)
					state_d = S_MUL_D;
			end
			S_MUL_D: begin
				cmd.mul_go = 1'b1;
				cmd.term   = pmd_pkg::TERM_D;
				cmd.chunk  = cnt_q;
				cmd.top    = (cnt_q == LAST_D);
				if (cnt_q == LAST_D) begin
					cnt_d   = '0;
					state_d = S_DRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DRAIN: begin
				state_d = S_TRUNC;
			end
			S_TRUNC: begin
				cmd.trunc = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_PREP))
		else $error("accepted item did not start the update sequence");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("output register loaded while holding an untaken result");

	a_deriv_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL_D && $past(state_q) == S_WAIT_D) |-> $past(status.div_done))
		else $error("derivative multiply started before the divider finished");

	a_busy_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.load_err)
		else $error("new item loaded while an update is in progress");
`endif

endmodule
